@@ design/scar_pkg.sv @@
// shared types, delay lengths and fixed-point constants for the stereo reverb
// no dependencies
package scar_pkg;

  typedef enum logic [3:0] {
    REG_WET_LEVEL    = 4'd0,
    REG_STEREO_WIDTH = 4'd1,
    REG_DAMPING      = 4'd2,
    REG_ROOM_SIZE    = 4'd3,
    REG_MONO_MODE    = 4'd4,
    REG_HPF_B0       = 4'd5,
    REG_HPF_A1       = 4'd6,
    REG_HPF_A2       = 4'd7
  } reg_idx_t;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;
  localparam int POS_W      = 11;
  localparam int AP_POS_W   = 10;

  localparam int K_FEED       = 983;
  localparam int K_DECAY_BASE = 45875;
  localparam int K_DECAY_SPAN = 18350;
  localparam int K_DAMP       = 26214;
  localparam int K_ONE        = 65536;

  localparam logic [15:0] RST_WET_LEVEL    = 16'd21845;
  localparam logic [15:0] RST_STEREO_WIDTH = 16'd65535;
  localparam logic [15:0] RST_DAMPING      = 16'd32768;
  localparam logic [15:0] RST_ROOM_SIZE    = 16'd32768;
  localparam logic [16:0] RST_HPF_B0       = 17'd64879;
  localparam logic signed [17:0] RST_HPF_A1 = -18'sd129752;
  localparam logic signed [17:0] RST_HPF_A2 = 18'sd64229;

  localparam logic [10:0] COMB_LEN_TAB [8] = '{
    11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
  };
  localparam logic [9:0] AP_LEN_TAB [4] = '{10'd556, 10'd441, 10'd341, 10'd225};

  function automatic logic [POS_W-1:0] comb_len(input int j);
    return COMB_LEN_TAB[3'(j)];
  endfunction

  function automatic logic [AP_POS_W-1:0] ap_len(input int j);
    return AP_LEN_TAB[2'(j)];
  endfunction

  function automatic int comb_total(input int count, input int spread);
    int s;
    s = 0;
    for (int i = 0; i < count; i++) s = s + 2 * int'(comb_len(i)) + spread;
    return s;
  endfunction

  function automatic int ap_total(input int count, input int spread);
    int s;
    s = 0;
    for (int i = 0; i < count; i++) s = s + 2 * int'(ap_len(i)) + spread;
    return s;
  endfunction

endpackage

@@ design/stereo_comb_allpass_reverb.sv @@
// stereo comb/all-pass reverb with one shared multiply-accumulate unit
// depends on scar_pkg and scar_ram
// processing: the fields are computed in turn on the single multiplier and the one delay
//   ram read port; a new input is taken only once the previous result has been handed to
//   the output register, and that hand-off waits while out_tvalid is held unaccepted
// reset: synchronous; after reset the delay ram is swept to zero, one word a cycle,
//   before the first input transfer
module stereo_comb_allpass_reverb
  import scar_pkg::*;
#(
  parameter int COMB_COUNT    = 8,
  parameter int ALLPASS_COUNT = 4,
  parameter int STEREO_SPREAD = 23,
  parameter int SAMPLE_BITS   = 24,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // left_in, right_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // dry_left, dry_right, wet_left, wet_right
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = SB + 4;
  localparam int BW  = 19;
  localparam int PW  = AW + BW;
  localparam int ACW = PW + 2;
  localparam int CC  = COMB_COUNT;
  localparam int AC  = ALLPASS_COUNT;
  localparam int KW  = $clog2(2 * CC);
  localparam int AKW = $clog2(2 * AC);
  localparam int MEM_DEPTH = comb_total(CC, STEREO_SPREAD) + ap_total(AC, STEREO_SPREAD);
  localparam int MAW = $clog2(MEM_DEPTH);

  localparam logic signed [ACW-1:0] SMAX   = {{(ACW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [ACW-1:0] SMIN   = ~SMAX;
  localparam logic signed [ACW-1:0] HALF16 = ACW'(32768);
  localparam logic signed [ACW-1:0] HALF17 = ACW'(65536);
  localparam logic signed [ACW-1:0] ONE_A  = ACW'(1);
  localparam logic signed [ACW-1:0] DEC0   = ACW'(K_DECAY_BASE);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECAY, S_DAMP, S_WET1, S_WET2, S_FEED, S_DRYL, S_DRYR, S_DRYW,
    C_ADDR, C_LP1, C_LP2, C_LP3, C_FB, C_WR, A_INIT, A_ADDR, A_UPD,
    M1, M2, M3, M4, M5, H1, H2, H3, H4, S_MONO, S_OUT
  } state_t;

  function automatic logic signed [SB-1:0] sat(input logic signed [ACW-1:0] v);
    if (v > SMAX) return SMAX[SB-1:0];
    else if (v < SMIN) return SMIN[SB-1:0];
    else return v[SB-1:0];
  endfunction

  function automatic logic signed [ACW-1:0] rnd16(input logic signed [ACW-1:0] v);
    return (v + HALF16) >>> 16;
  endfunction

  function automatic logic signed [ACW-1:0] rnd17(input logic signed [ACW-1:0] v);
    return (v + HALF17) >>> 17;
  endfunction

  state_t state_r;

  logic [15:0]        wet_level_r, width_r, damping_r, room_r;
  logic               mono_r;
  logic [16:0]        b0_r;
  logic signed [17:0] a1_r, a2_r;

  logic signed [SB-1:0] in_l_r, in_r_r, feed_r, dry_l_r, dry_r_r, co_r, x_r;
  logic [16:0]          decay_r;
  logic [15:0]          damp_r;
  logic [17:0]          wet1_r, wet2_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [AW-1:0] t_r;
  logic signed [SB+3:0] sum_l_r, sum_r_r;
  logic [KW-1:0]        k_r;
  logic [AKW-1:0]       ak_r;
  logic                 ch_r;
  logic [MAW-1:0]       base_r, clr_r;
  logic                 out_tvalid_r;
  logic [4*SB-1:0]      out_data_r;

  logic signed [SB-1:0] lp_r   [2*CC];
  logic [POS_W-1:0]     cpos_r [2*CC];
  logic [AP_POS_W-1:0]  apos_r [2*AC];
  logic signed [SB-1:0] apv_r  [2];
  logic signed [SB-1:0] hx1_r [2], hx2_r [2], hy1_r [2], hy2_r [2], wet_r [2];

  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [ACW-1:0] prod_x;
  logic [17:0]           w_c;
  logic                  cch_c, ach_c;
  logic [KW-1:0]         cj_c;
  logic [AKW-1:0]        aj_c;
  logic [POS_W-1:0]      clen_c, cpos_inc;
  logic [AP_POS_W-1:0]   alen_c, apos_inc;
  logic signed [SB-1:0]  ap_in_c, ap_b_c, own_c, oth_c, y_c;
  logic signed [ACW-1:0] ap_half_c;
  logic                  ram_we;
  logic [MAW-1:0]        ram_waddr, ram_raddr, comb_addr, ap_addr;
  logic [SB-1:0]         ram_wdata, ram_rdata;

  assign prod_x   = ACW'(prod_r);
  assign w_c      = {1'b0, wet_level_r, 1'b0} + {2'b00, wet_level_r};
  assign cch_c    = (k_r >= KW'(CC));
  assign cj_c     = cch_c ? k_r - KW'(CC) : k_r;
  assign clen_c   = comb_len(int'(cj_c)) + (cch_c ? POS_W'(STEREO_SPREAD) : '0);
  assign cpos_inc = cpos_r[k_r] + 1'b1;
  assign comb_addr = base_r + MAW'(cpos_r[k_r]);
  assign ach_c    = (ak_r >= AKW'(AC));
  assign aj_c     = ach_c ? ak_r - AKW'(AC) : ak_r;
  assign alen_c   = ap_len(int'(aj_c)) + (ach_c ? AP_POS_W'(STEREO_SPREAD) : '0);
  assign apos_inc = apos_r[ak_r] + 1'b1;
  assign ap_addr  = base_r + MAW'(apos_r[ak_r]);
  assign ap_in_c  = apv_r[ach_c];
  assign ap_b_c   = signed'(ram_rdata);
  assign ap_half_c = (ACW'(ap_b_c) + ONE_A) >>> 1;
  assign own_c    = apv_r[ch_r];
  assign oth_c    = apv_r[~ch_r];
  assign y_c      = sat(rnd16(acc_r - prod_x));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DECAY: begin mul_a = AW'({1'b0, room_r});    mul_b = BW'(K_DECAY_SPAN); end
      S_DAMP:  begin mul_a = AW'({1'b0, damping_r}); mul_b = BW'(K_DAMP); end
      S_WET1:  begin mul_a = AW'({1'b0, w_c}); mul_b = BW'(K_ONE + int'(width_r)); end
      S_WET2:  begin mul_a = AW'({1'b0, w_c}); mul_b = BW'(K_ONE - int'(width_r)); end
      S_FEED:  begin mul_a = AW'(in_l_r) + AW'(in_r_r); mul_b = BW'(K_FEED); end
      S_DRYL:  begin mul_a = AW'(in_l_r); mul_b = BW'(K_ONE - int'(wet_level_r)); end
      S_DRYR:  begin mul_a = AW'(in_r_r); mul_b = BW'(K_ONE - int'(wet_level_r)); end
      C_LP1:   begin mul_a = AW'(lp_r[k_r]); mul_b = BW'({1'b0, damp_r}); end
      C_LP2:   begin mul_a = AW'(co_r); mul_b = BW'(K_ONE - int'(damp_r)); end
      C_FB:    begin mul_a = AW'(lp_r[k_r]); mul_b = BW'({1'b0, decay_r}); end
      M1:      begin mul_a = AW'(own_c); mul_b = BW'({1'b0, wet1_r}); end
      M2:      begin mul_a = AW'(oth_c); mul_b = BW'({1'b0, wet2_r}); end
      M4:      begin mul_a = t_r; mul_b = BW'({1'b0, w_c}); end
      H1: begin
        mul_a = AW'(x_r) - (AW'(hx1_r[ch_r]) <<< 1) + AW'(hx2_r[ch_r]);
        mul_b = BW'({1'b0, b0_r});
      end
      H2:      begin mul_a = AW'(hy1_r[ch_r]); mul_b = BW'(a1_r); end
      H3:      begin mul_a = AW'(hy2_r[ch_r]); mul_b = BW'(a2_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_raddr = (state_r == A_ADDR) ? ap_addr : comb_addr;
    unique case (state_r)
      S_CLEAR: ram_we = 1'b1;
      C_WR: begin
        ram_we    = 1'b1;
        ram_waddr = comb_addr;
        ram_wdata = sat(rnd16(prod_x) + ACW'(feed_r));
      end
      A_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = ap_addr;
        ram_wdata = sat(ACW'(ap_in_c) + ap_half_c);
      end
      default: ram_we = 1'b0;
    endcase
  end

  scar_ram #(.WIDTH(SB), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
      ak_r         <= '0;
      ch_r         <= 1'b0;
      base_r       <= '0;
      wet_level_r  <= RST_WET_LEVEL;
      width_r      <= RST_STEREO_WIDTH;
      damping_r    <= RST_DAMPING;
      room_r       <= RST_ROOM_SIZE;
      mono_r       <= 1'b0;
      b0_r         <= RST_HPF_B0;
      a1_r         <= RST_HPF_A1;
      a2_r         <= RST_HPF_A2;
      for (int i = 0; i < 2 * CC; i++) begin
        lp_r[i]   <= '0;
        cpos_r[i] <= '0;
      end
      for (int i = 0; i < 2 * AC; i++) apos_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        hx1_r[i] <= '0;
        hx2_r[i] <= '0;
        hy1_r[i] <= '0;
        hy2_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WET_LEVEL:    wet_level_r <= cfg_data[15:0];
          REG_STEREO_WIDTH: width_r     <= cfg_data[15:0];
          REG_DAMPING:      damping_r   <= cfg_data[15:0];
          REG_ROOM_SIZE:    room_r      <= cfg_data[15:0];
          REG_MONO_MODE:    mono_r      <= cfg_data[0];
          REG_HPF_B0:       b0_r        <= cfg_data[16:0];
          REG_HPF_A1:       a1_r        <= signed'(cfg_data[17:0]);
          REG_HPF_A2:       a2_r        <= signed'(cfg_data[17:0]);
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MAW'(MEM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            in_l_r  <= signed'(in_tdata[SB-1:0]);
            in_r_r  <= signed'(in_tdata[2*SB-1:SB]);
            state_r <= S_DECAY;
          end
        end
        S_DECAY: state_r <= S_DAMP;
        S_DAMP: begin
          decay_r <= 17'(rnd16(prod_x) + DEC0);
          state_r <= S_WET1;
        end
        S_WET1: begin
          damp_r  <= 16'(rnd16(prod_x));
          state_r <= S_WET2;
        end
        S_WET2: begin
          wet1_r  <= 18'(rnd17(prod_x));
          state_r <= S_FEED;
        end
        S_FEED: begin
          wet2_r  <= 18'(rnd17(prod_x));
          state_r <= S_DRYL;
        end
        S_DRYL: begin
          feed_r  <= sat(rnd16(prod_x));
          state_r <= S_DRYR;
        end
        S_DRYR: begin
          dry_l_r <= sat(rnd16(prod_x));
          state_r <= S_DRYW;
        end
        S_DRYW: begin
          dry_r_r <= sat(rnd16(prod_x));
          k_r     <= '0;
          base_r  <= '0;
          sum_l_r <= '0;
          sum_r_r <= '0;
          state_r <= C_ADDR;
        end
        C_ADDR: state_r <= C_LP1;
        C_LP1: begin
          co_r    <= signed'(ram_rdata);
          state_r <= C_LP2;
        end
        C_LP2: begin
          acc_r   <= prod_x;
          state_r <= C_LP3;
        end
        C_LP3: begin
          lp_r[k_r] <= sat(rnd16(acc_r + prod_x));
          state_r   <= C_FB;
        end
        C_FB: state_r <= C_WR;
        C_WR: begin
          cpos_r[k_r] <= (cpos_inc >= clen_c) ? '0 : cpos_inc;
          base_r      <= base_r + MAW'(clen_c);
          if (cch_c) sum_r_r <= sum_r_r + (SB+4)'(co_r);
          else sum_l_r <= sum_l_r + (SB+4)'(co_r);
          if (k_r == KW'(2 * CC - 1)) begin
            state_r <= A_INIT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= C_ADDR;
          end
        end
        A_INIT: begin
          apv_r[0] <= sat(ACW'(sum_l_r));
          apv_r[1] <= sat(ACW'(sum_r_r));
          ak_r     <= '0;
          state_r  <= A_ADDR;
        end
        A_ADDR: state_r <= A_UPD;
        A_UPD: begin
          apv_r[ach_c] <= sat(ACW'(ap_b_c) - ACW'(ap_in_c));
          apos_r[ak_r] <= (apos_inc >= alen_c) ? '0 : apos_inc;
          base_r       <= base_r + MAW'(alen_c);
          if (ak_r == AKW'(2 * AC - 1)) begin
            ch_r    <= 1'b0;
            state_r <= M1;
          end else begin
            ak_r    <= ak_r + 1'b1;
            state_r <= A_ADDR;
          end
        end
        M1: state_r <= M2;
        M2: begin
          acc_r   <= prod_x;
          state_r <= M3;
        end
        M3: begin
          t_r     <= AW'(rnd16(acc_r + prod_x));
          state_r <= M4;
        end
        M4: state_r <= M5;
        M5: begin
          x_r     <= sat(rnd16(prod_x));
          state_r <= H1;
        end
        H1: state_r <= H2;
        H2: begin
          acc_r   <= prod_x;
          state_r <= H3;
        end
        H3: begin
          acc_r   <= acc_r - prod_x;
          state_r <= H4;
        end
        H4: begin
          hx2_r[ch_r] <= hx1_r[ch_r];
          hx1_r[ch_r] <= x_r;
          hy2_r[ch_r] <= hy1_r[ch_r];
          hy1_r[ch_r] <= y_c;
          wet_r[ch_r] <= y_c;
          if (ch_r) begin
            state_r <= S_MONO;
          end else begin
            ch_r    <= 1'b1;
            state_r <= M1;
          end
        end
        S_MONO: begin
          if (mono_r) wet_r[0] <= SB'(((SB+1)'(wet_r[0]) + (SB+1)'(wet_r[1]) + 1'b1) >>> 1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= {wet_r[1], wet_r[0], dry_r_r, dry_l_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

@@ design/scar_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module scar_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ test/stereo_comb_allpass_reverb_chk.sv @@
// checker for the stereo reverb: watches input, config and output transfers,
// predicts each output sample set and compares field by field; depends on scar_pkg
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_chk
  import scar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NCOMB = 8;
  localparam int NAP   = 4;
  localparam int SPREAD = 23;
  localparam longint SMAX = 64'sd8388607;
  localparam longint SMIN = -64'sd8388608;

  longint wet_lvl, width, damping, room, b0, a1, a2;
  bit     mono;

  longint comb_mem [2][NCOMB][1700];
  longint comb_lp  [2][NCOMB];
  int     comb_pos [2][NCOMB];
  longint ap_mem   [2][NAP][640];
  int     ap_pos   [2][NAP];
  longint hist     [2][4];

  logic [95:0] expected_q[$];

  function automatic longint rnd_shift(longint v, int s);
    longint t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint comb_tick(int ch, int j, longint x, longint decay, longint damp);
    int len;
    int p;
    longint y;
    len = int'(COMB_LEN_TAB[j]) + (ch ? SPREAD : 0);
    p = comb_pos[ch][j];
    y = comb_mem[ch][j][p];
    comb_lp[ch][j] = clip(rnd_shift(damp * comb_lp[ch][j] + y * (65536 - damp), 16));
    comb_mem[ch][j][p] = clip(rnd_shift(decay * comb_lp[ch][j], 16) + x);
    comb_pos[ch][j] = (p + 1 >= len) ? 0 : p + 1;
    return y;
  endfunction

  function automatic longint ap_tick(int ch, int j, longint x);
    int len;
    int p;
    longint b;
    len = int'(AP_LEN_TAB[j]) + (ch ? SPREAD : 0);
    p = ap_pos[ch][j];
    b = ap_mem[ch][j][p];
    ap_mem[ch][j][p] = clip(x + rnd_shift(b, 1));
    ap_pos[ch][j] = (p + 1 >= len) ? 0 : p + 1;
    return clip(b - x);
  endfunction

  function automatic longint highpass(int ch, longint x);
    longint acc;
    longint y;
    acc = b0 * x - 2 * b0 * hist[ch][0] + b0 * hist[ch][1]
        - a1 * hist[ch][2] - a2 * hist[ch][3];
    y = clip(rnd_shift(acc, 16));
    hist[ch][1] = hist[ch][0];
    hist[ch][0] = x;
    hist[ch][3] = hist[ch][2];
    hist[ch][2] = y;
    return y;
  endfunction

  function automatic logic [95:0] reverb_sample(logic [47:0] d);
    longint l, r, decay, damp, w, wet1, wet2, feed, sl, sr, ol, orr, wl, wr, dl, dr;
    l = longint'($signed(d[23:0]));
    r = longint'($signed(d[47:24]));
    decay = 45875 + rnd_shift(18350 * room, 16);
    damp  = rnd_shift(26214 * damping, 16);
    w     = 3 * wet_lvl;
    wet1  = rnd_shift(w * (65536 + width), 17);
    wet2  = rnd_shift(w * (65536 - width), 17);
    feed  = clip(rnd_shift((l + r) * 983, 16));
    sl = 0;
    sr = 0;
    for (int j = 0; j < NCOMB; j++) begin
      sl += comb_tick(0, j, feed, decay, damp);
      sr += comb_tick(1, j, feed, decay, damp);
    end
    ol = clip(sl);
    orr = clip(sr);
    for (int j = 0; j < NAP; j++) begin
      ol = ap_tick(0, j, ol);
      orr = ap_tick(1, j, orr);
    end
    wl = highpass(0, clip(rnd_shift(rnd_shift(ol * wet1 + orr * wet2, 16) * w, 16)));
    wr = highpass(1, clip(rnd_shift(rnd_shift(orr * wet1 + ol * wet2, 16) * w, 16)));
    if (mono) wl = clip(rnd_shift(wl + wr, 1));
    dl = clip(rnd_shift(l * (65536 - wet_lvl), 16));
    dr = clip(rnd_shift(r * (65536 - wet_lvl), 16));
    return {wr[23:0], wl[23:0], dr[23:0], dl[23:0]};
  endfunction

  assign pending = expected_q.size();

  always_ff @(posedge clk) begin
    logic [95:0] exp_v;
    if (!rst_n) begin
      wet_lvl = 21845; width = 65535; damping = 32768; room = 32768;
      mono = 0; b0 = 64879; a1 = -129752; a2 = 64229;
      comb_lp = '{default: '{default: 0}};
      comb_pos = '{default: '{default: 0}};
      ap_pos = '{default: '{default: 0}};
      hist = '{default: '{default: 0}};
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < NCOMB; j++)
          for (int k = 0; k < 1700; k++) comb_mem[c][j][k] = 0;
        for (int j = 0; j < NAP; j++)
          for (int k = 0; k < 640; k++) ap_mem[c][j][k] = 0;
      end
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_WET_LEVEL:    wet_lvl = cfg_data[15:0];
          REG_STEREO_WIDTH: width = cfg_data[15:0];
          REG_DAMPING:      damping = cfg_data[15:0];
          REG_ROOM_SIZE:    room = cfg_data[15:0];
          REG_MONO_MODE:    mono = cfg_data[0];
          REG_HPF_B0:       b0 = cfg_data[16:0];
          REG_HPF_A1:       a1 = longint'($signed(cfg_data));
          REG_HPF_A2:       a2 = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_q.push_back(reverb_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output transfer %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = expected_q.pop_front();
          if (exp_v !== out_tdata) begin
            if (fail_count < 10)
              $display("mismatch dl %h/%h dr %h/%h wl %h/%h wr %h/%h",
                       exp_v[23:0], out_tdata[23:0], exp_v[47:24], out_tdata[47:24],
                       exp_v[71:48], out_tdata[71:48], exp_v[95:72], out_tdata[95:72]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/stereo_comb_allpass_reverb_tb.sv @@
// top-level bench for the stereo reverb: clock, reset, config writes, sample
// stimulus with random gaps and stalls; depends on the block, scar_pkg and the checker
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_tb;
  import scar_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [95:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_index;
  logic [17:0] cfg_data;
  int          fail_count, pending;
  bit          hold_off;
  int          idle_cycles;

  stereo_comb_allpass_reverb u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stereo_comb_allpass_reverb_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // output side: random stall per transfer, plus one long hold-off
  initial begin
    int gap;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0 || hold_off) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [17:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [23:0] l, logic signed [23:0] r, bit gaps);
    if (gaps) repeat ($urandom_range(0, 10)) @(posedge clk);
    in_tvalid <= 1;
    in_tdata  <= {r, l};
    @(posedge clk iff in_tready);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 2047)) - 24'd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] edges [6] = '{24'h7fffff, 24'h800000, 24'h0, 24'h1, 24'hffffff, 24'h555555};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    hold_off = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    foreach (edges[i])
      foreach (edges[k]) if (k < 3) send_sample(edges[i], edges[k], 0);
    drain();
    write_reg(REG_WET_LEVEL, 18'd65535);
    write_reg(REG_STEREO_WIDTH, 18'd0);
    write_reg(REG_DAMPING, 18'd65535);
    write_reg(REG_ROOM_SIZE, 18'd65535);
    write_reg(REG_MONO_MODE, 18'd1);
    write_reg(REG_HPF_B0, 18'h1ffff);
    write_reg(REG_HPF_A1, 18'h20000);
    write_reg(REG_HPF_A2, 18'h1ffff);
    write_reg(reg_idx_t'(4'd12), 18'h3ffff);
    for (int i = 0; i < 6; i++) send_sample(24'h7fffff, 24'h7fffff, 0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 1) begin
        write_reg(REG_WET_LEVEL, 18'd0);
        write_reg(REG_DAMPING, 18'd0);
        write_reg(REG_ROOM_SIZE, 18'd0);
        write_reg(REG_MONO_MODE, 18'd0);
        write_reg(REG_HPF_B0, 18'd0);
        write_reg(REG_HPF_A1, 18'h1ffff);
        write_reg(REG_HPF_A2, 18'h20000);
      end else begin
        write_reg(REG_WET_LEVEL, 18'($urandom_range(0, 65535)));
        write_reg(REG_STEREO_WIDTH, 18'($urandom_range(0, 65535)));
        write_reg(REG_DAMPING, 18'($urandom_range(0, 65535)));
        write_reg(REG_ROOM_SIZE, 18'($urandom_range(0, 65535)));
        write_reg(REG_MONO_MODE, 18'($urandom_range(0, 1)));
        write_reg(REG_HPF_B0, 18'($urandom_range(60000, 65536)));
        write_reg(REG_HPF_A1, 18'($urandom_range(0, 18'h3ffff)));
        write_reg(REG_HPF_A2, 18'($urandom_range(0, 18'h3ffff)));
      end
      if (phase == 2) begin
        hold_off = 1;
        fork
          repeat (3000) @(posedge clk);
          for (int i = 0; i < 20; i++) send_sample(rand_sample(), rand_sample(), 0);
        join_any
        hold_off = 0;
        wait fork;
      end
      for (int i = 0; i < 180; i++) send_sample(rand_sample(), rand_sample(), i % 60 >= 20);
    end
    drain();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/scar_pkg.sv
design/scar_ram.sv
design/stereo_comb_allpass_reverb.sv
test/stereo_comb_allpass_reverb_chk.sv
test/stereo_comb_allpass_reverb_tb.sv
